// ===== rtl/core/reservoir_sampler_macros.svh =====
// Assertion macros shared by the reservoir sampler RTL.
`ifndef RESERVOIR_SAMPLER_MACROS_SVH
`define RESERVOIR_SAMPLER_MACROS_SVH
`ifndef SYNTH
`define RS_ASSERT_WHEN(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("reservoir sampler check failed");
`define RS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("reservoir sampler check failed");
`define RS_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("reservoir sampler check failed");
`else
`define RS_ASSERT_WHEN(name, clk, rst_n, ante, cons)
`define RS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`define RS_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/rs_pkg.sv =====
package rs_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] value;
        logic        is_last;
        logic [31:0] accept_fraction;
        logic [7:0]  slot_choice;
        logic [7:0]  read_slot;
        logic [3:0]  read_position;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic        kept;
        logic [7:0]  slot;
        logic [31:0] seen_count;
        logic        error;
    } out_item_t;

    localparam logic REG_RESERVOIR_SIZE = 1'b0;
    localparam logic REG_ELEMENT_COUNT  = 1'b1;

    localparam logic MODE_OFFER = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam int CFG_DATA_W = 9;

endpackage

// ===== rtl/core/rs_ram.sv =====
module rs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/reservoir_sampler.sv =====
// Reservoir sampler: keeps a uniform random sample of records from a stream.
// Input items arrive on in_valid/in_stall/in_item, results leave on
// out_valid/out_stall/out_item, and every input item produces one result.
// In offer mode an item carries one record element together with the external
// random draws; the first element of each record decides whether the record is
// kept and in which slot, and kept elements are written to the sample memory.
// In read mode an item returns one stored element.
// An offer item passes through S_MUL and then S_EXEC: the acceptance product is
// registered in S_MUL and the decision and memory write happen in S_EXEC.
// A read item passes through S_READ, where the registered memory read is returned.
// A result waits in an output register; the next item is accepted while it
// waits, and the block holds in its last step while the receiver stalls and
// that register is still full.
// Reset clears the counters, the record in progress and the configuration
// (one slot, one element per record); the sample memory is not cleared, and
// configuration is written through cfg_write_en, cfg_index and cfg_data.
`include "reservoir_sampler_macros.svh"

module reservoir_sampler #(
    parameter int MAX_RESERVOIR = 256,
    parameter int MAX_ELEMENTS  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write_en,
    input  logic                    cfg_index,
    input  logic [rs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  rs_pkg::in_item_t        in_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output rs_pkg::out_item_t       out_item
);

    localparam int SLOT_W = (MAX_RESERVOIR > 1) ? $clog2(MAX_RESERVOIR) : 1;
    localparam int POS_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int KW     = $clog2(MAX_RESERVOIR + 1);
    localparam int DEPTH  = MAX_RESERVOIR * MAX_ELEMENTS;
    localparam int AW     = $clog2(DEPTH > 1 ? DEPTH : 2);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_EXEC = 4'b0100,
        S_READ = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    rs_pkg::in_item_t  item_reg;
    logic [31:0]       prod_hi_reg;
    logic              rd_oob_reg;

    logic [8:0]        rsize_reg;
    logic [4:0]        ecount_reg;
    logic [31:0]       records_seen_reg, records_seen_next;
    logic [KW-1:0]     records_stored_reg, records_stored_next;
    logic [POS_W-1:0]  element_position_reg, element_position_next;
    logic              keep_current_reg, keep_current_next;
    logic [SLOT_W-1:0] current_slot_reg, current_slot_next;

    logic              out_valid_reg, out_valid_next;
    rs_pkg::out_item_t out_reg, out_next;

    logic [31:0]       k32, w32, seen_inc, pos32, stored32, choice32, rs32, rp32;
    logic [63:0]       product;
    logic              in_accept, out_free, out_load, exec_done;
    logic              first, err;
    logic              ram_we, ram_re, rd_accept;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [31:0]       waddr32, raddr32;
    logic [15:0]       ram_rdata;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign rd_accept = in_accept && (in_item.mode == rs_pkg::MODE_READ);

    always_comb
    begin
        if (rsize_reg == 9'd0)
        begin
            k32 = 32'd1;
        end
        else if (32'(rsize_reg) > 32'(MAX_RESERVOIR))
        begin
            k32 = 32'(MAX_RESERVOIR);
        end
        else
        begin
            k32 = 32'(rsize_reg);
        end
        if (ecount_reg == 5'd0)
        begin
            w32 = 32'd1;
        end
        else if (32'(ecount_reg) > 32'(MAX_ELEMENTS))
        begin
            w32 = 32'(MAX_ELEMENTS);
        end
        else
        begin
            w32 = 32'(ecount_reg);
        end
    end

    assign seen_inc = (records_seen_reg == 32'hFFFF_FFFF) ? records_seen_reg
                                                          : records_seen_reg + 32'd1;
    assign product  = 64'(item_reg.accept_fraction) * 64'(seen_inc);

    assign pos32    = 32'(element_position_reg);
    assign stored32 = 32'(records_stored_reg);
    assign choice32 = 32'(item_reg.slot_choice);
    assign first    = (element_position_reg == '0);

    always_comb
    begin
        records_seen_next     = records_seen_reg;
        records_stored_next   = records_stored_reg;
        keep_current_next     = keep_current_reg;
        current_slot_next     = current_slot_reg;
        element_position_next = element_position_reg;
        err                   = 1'b0;
        if (first)
        begin
            records_seen_next = seen_inc;
            if (stored32 < k32)
            begin
                keep_current_next   = 1'b1;
                current_slot_next   = stored32[SLOT_W-1:0];
                records_stored_next = records_stored_reg + KW'(1);
            end
            else if (prod_hi_reg < k32)
            begin
                if (choice32 < k32)
                begin
                    keep_current_next = 1'b1;
                    current_slot_next = choice32[SLOT_W-1:0];
                end
                else
                begin
                    keep_current_next = 1'b0;
                    current_slot_next = '0;
                    err               = 1'b1;
                end
            end
            else
            begin
                keep_current_next = 1'b0;
                current_slot_next = '0;
            end
        end
        if (pos32 + 32'd1 >= w32)
        begin
            if (!item_reg.is_last)
            begin
                err = 1'b1;
            end
            element_position_next = '0;
        end
        else if (item_reg.is_last)
        begin
            err                   = 1'b1;
            element_position_next = '0;
        end
        else
        begin
            element_position_next = element_position_reg + POS_W'(1);
        end
    end

    assign waddr32   = 32'(current_slot_next) * 32'(MAX_ELEMENTS) + pos32;
    assign ram_waddr = waddr32[AW-1:0];
    assign exec_done = (state_reg == S_EXEC) && out_free;
    assign ram_we    = exec_done && keep_current_next;

    assign rs32      = 32'(in_item.read_slot);
    assign rp32      = 32'(in_item.read_position);
    assign raddr32   = rs32 * 32'(MAX_ELEMENTS) + rp32;
    assign ram_raddr = raddr32[AW-1:0];
    assign ram_re    = rd_accept;

    rs_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        out_next   = out_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (in_item.mode == rs_pkg::MODE_READ) ? S_READ : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_load            = 1'b1;
                    out_next.read_value = '0;
                    out_next.kept       = keep_current_next;
                    out_next.slot       = keep_current_next ?
                                          8'(32'(current_slot_next)) : 8'd0;
                    out_next.seen_count = records_seen_next;
                    out_next.error      = err;
                    state_next          = S_IDLE;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_load            = 1'b1;
                    out_next.read_value = rd_oob_reg ? 16'd0 : ram_rdata;
                    out_next.kept       = 1'b0;
                    out_next.slot       = 8'd0;
                    out_next.seen_count = records_seen_reg;
                    out_next.error      = 1'b0;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            out_valid_reg        <= 1'b0;
            rsize_reg            <= 9'd1;
            ecount_reg           <= 5'd1;
            records_seen_reg     <= '0;
            records_stored_reg   <= '0;
            element_position_reg <= '0;
            keep_current_reg     <= 1'b0;
            current_slot_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    rs_pkg::REG_RESERVOIR_SIZE: rsize_reg  <= cfg_data;
                    rs_pkg::REG_ELEMENT_COUNT:  ecount_reg <= cfg_data[4:0];
                    default:                    rsize_reg  <= rsize_reg;
                endcase
            end
            if (exec_done)
            begin
                records_seen_reg     <= records_seen_next;
                records_stored_reg   <= records_stored_next;
                element_position_reg <= element_position_next;
                keep_current_reg     <= keep_current_next;
                current_slot_reg     <= current_slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg   <= in_item;
            rd_oob_reg <= (rs32 >= 32'(MAX_RESERVOIR)) || (rp32 >= 32'(MAX_ELEMENTS));
        end
        if (state_reg == S_MUL)
        begin
            prod_hi_reg <= product[63:32];
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    // The stored-record count and the seen count only grow between resets.
    `RS_ASSERT_NEXT(a_stored_grows, clk, rst_n, 1'b1, records_stored_reg >= $past(records_stored_reg))
    `RS_ASSERT_NEXT(a_seen_grows, clk, rst_n, 1'b1, records_seen_reg >= $past(records_seen_reg))
    `RS_ASSERT_NEVER(a_no_rw_overlap, clk, rst_n, ram_we && ram_re)
    `RS_ASSERT_WHEN(a_load_when_free, clk, rst_n, out_load, !out_valid_reg || !out_stall)
    `RS_ASSERT_NEXT(a_read_path, clk, rst_n, rd_accept, state_reg == S_READ)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned HOLD_CYCLES    = 150;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write_en = 1'b0;
    logic                          cfg_index = rs_pkg::REG_RESERVOIR_SIZE;
    logic [rs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    rs_pkg::in_item_t              in_item = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    rs_pkg::out_item_t             out_item;

    // Predictor state: sample memory with write tracking, counters and registers.
    logic [15:0]           sample_mem [0:4095];
    bit                    mem_written [0:4095];
    int unsigned           written_addrs [$];
    logic [31:0]           records_counted = '0;
    int unsigned           records_held = 0;
    logic [3:0]            elem_index = '0;
    bit                    keeping = 1'b0;
    logic [7:0]            target_slot = '0;
    logic [8:0]            size_reg = 9'd1;
    logic [4:0]            width_reg = 5'd1;

    rs_pkg::out_item_t     pending_results [$];

    int unsigned           send_idle_pct = 0;
    int unsigned           stall_pct = 0;
    int unsigned           hold_len = 0;
    int unsigned           hold_left = 0;
    int unsigned           quiet_cycles = 0;

    int unsigned           failures = 0;
    int unsigned           items_sent = 0;
    int unsigned           results_checked = 0;
    int unsigned           reads_sent = 0;
    int unsigned           records_started = 0;
    int unsigned           records_kept = 0;
    int unsigned           errors_flagged = 0;
    int unsigned           reg_writes = 0;

    reservoir_sampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned eff_k();
        if (size_reg == 0)
            return 1;
        if (size_reg > 256)
            return 256;
        return size_reg;
    endfunction

    function automatic int unsigned eff_w();
        if (width_reg == 0)
            return 1;
        if (width_reg > 16)
            return 16;
        return width_reg;
    endfunction

    function automatic rs_pkg::out_item_t sample_step(input rs_pkg::in_item_t it);
        rs_pkg::out_item_t res;
        int unsigned       k;
        int unsigned       w;
        bit                err;
        logic [11:0]       addr;
        res = '0;
        err = 1'b0;
        k = eff_k();
        w = eff_w();
        if (it.mode == rs_pkg::MODE_READ)
        begin
            reads_sent++;
            res.read_value = sample_mem[{it.read_slot, it.read_position}];
            res.seen_count = records_counted;
            return res;
        end
        if (elem_index == 0)
        begin
            records_started++;
            if (records_counted != 32'hFFFF_FFFF)
                records_counted++;
            if (records_held < k)
            begin
                keeping = 1'b1;
                target_slot = 8'(records_held);
                records_held++;
            end
            else if (64'(it.accept_fraction) * 64'(records_counted) < (64'(k) << 32))
            begin
                if (int'(it.slot_choice) < k)
                begin
                    keeping = 1'b1;
                    target_slot = it.slot_choice;
                end
                else
                begin
                    keeping = 1'b0;
                    target_slot = '0;
                    err = 1'b1;
                end
            end
            else
            begin
                keeping = 1'b0;
                target_slot = '0;
            end
            if (keeping)
                records_kept++;
        end
        if (keeping)
        begin
            addr = {target_slot, elem_index};
            sample_mem[addr] = it.value;
            if (!mem_written[addr])
            begin
                mem_written[addr] = 1'b1;
                written_addrs.push_back(addr);
            end
        end
        res.kept = keeping;
        res.slot = keeping ? target_slot : 8'd0;
        res.seen_count = records_counted;
        if (int'(elem_index) + 1 >= w)
        begin
            if (!it.is_last)
                err = 1'b1;
            elem_index = '0;
        end
        else if (it.is_last)
        begin
            err = 1'b1;
            elem_index = '0;
        end
        else
            elem_index++;
        res.error = err;
        if (err)
            errors_flagged++;
        return res;
    endfunction

    function automatic rs_pkg::in_item_t offer_item(input logic [15:0] value, input bit last,
                                                    input logic [31:0] frac,
                                                    input logic [7:0] choice);
        rs_pkg::in_item_t it;
        it.mode = rs_pkg::MODE_OFFER;
        it.value = value;
        it.is_last = last;
        it.accept_fraction = frac;
        it.slot_choice = choice;
        it.read_slot = 8'($urandom_range(0, 255));
        it.read_position = 4'($urandom_range(0, 15));
        return it;
    endfunction

    function automatic rs_pkg::in_item_t read_item(input logic [7:0] slot,
                                                   input logic [3:0] pos);
        rs_pkg::in_item_t it;
        it.mode = rs_pkg::MODE_READ;
        it.value = 16'($urandom_range(0, 65535));
        it.is_last = 1'($urandom_range(0, 1));
        it.accept_fraction = $urandom();
        it.slot_choice = 8'($urandom_range(0, 255));
        it.read_slot = slot;
        it.read_position = pos;
        return it;
    endfunction

    function automatic logic [31:0] pick_fraction();
        int unsigned s = $urandom_range(0, 15);
        if (s == 15)
            return 32'hFFFF_FFFF;
        if (s == 14)
            return '0;
        return $urandom() >> s;
    endfunction

    function automatic logic [7:0] pick_choice();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, eff_k() - 1));
    endfunction

    task automatic send_item(input rs_pkg::in_item_t it);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        pending_results.push_back(sample_step(it));
    endtask

    task automatic send_read_random();
        int unsigned addr;
        addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        send_item(read_item(addr[11:4], addr[3:0]));
    endtask

    task automatic send_record();
        int unsigned w;
        int unsigned len;
        int unsigned shape;
        bit          no_mark;
        w = eff_w();
        len = w;
        shape = $urandom_range(0, 99);
        no_mark = (shape >= 6 && shape < 12);
        if (shape < 6 && w > 1)
            len = $urandom_range(1, w - 1);
        for (int unsigned e = 0; e < len; e++)
        begin
            if (written_addrs.size() != 0 && $urandom_range(0, 9) == 0)
                send_read_random();
            send_item(offer_item(16'($urandom_range(0, 65535)), (e == len - 1) && !no_mark,
                                 pick_fraction(), pick_choice()));
        end
    endtask

    task automatic run_traffic(input int unsigned n_items);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if (written_addrs.size() != 0 && $urandom_range(0, 99) < 20)
                send_read_random();
            else
                send_record();
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [rs_pkg::CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        reg_writes++;
        if (idx == rs_pkg::REG_RESERVOIR_SIZE)
            size_reg = data;
        else
            width_reg = data[4:0];
        @(posedge clk);
    endtask

    // Default configuration holds one record of one element.
    task automatic test_reset_defaults();
        send_item(offer_item(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF));
        send_item(read_item(8'd0, 4'd0));
        send_item(offer_item(16'h0000, 1'b1, 32'h0000_0000, 8'd0));
        send_item(offer_item(16'h1234, 1'b1, 32'hFFFF_FFFF, 8'd0));
        send_item(offer_item(16'h5A5A, 1'b1, 32'h0000_0000, 8'hFF));
        send_item(offer_item(16'hA5A5, 1'b0, 32'h0000_0000, 8'd0));
        send_item(read_item(8'd0, 4'd0));
        drain_results();
    endtask

    task automatic test_register_limits();
        write_reg(rs_pkg::REG_RESERVOIR_SIZE, 9'd0);
        write_reg(rs_pkg::REG_ELEMENT_COUNT, 9'd0);
        send_item(offer_item(16'h00FF, 1'b1, 32'h0000_0000, 8'd1));
        drain_results();
        write_reg(rs_pkg::REG_RESERVOIR_SIZE, 9'd511);
        write_reg(rs_pkg::REG_ELEMENT_COUNT, 9'd31);
        send_item(offer_item(16'h0001, 1'b0, 32'h8000_0000, 8'd7));
        send_item(offer_item(16'h8002, 1'b0, 32'h0000_0000, 8'd0));
        send_item(offer_item(16'h7FFD, 1'b1, 32'h0000_0000, 8'd0));
        send_item(read_item(8'd1, 4'd2));
        send_item(read_item(8'd1, 4'd0));
        drain_results();
    endtask

    task automatic test_record_framing();
        write_reg(rs_pkg::REG_RESERVOIR_SIZE, 9'd1);
        write_reg(rs_pkg::REG_ELEMENT_COUNT, 9'd2);
        send_item(offer_item(16'hBEEF, 1'b0, 32'h0000_0000, 8'd0));
        send_item(read_item(8'd1, 4'd1));
        send_item(offer_item(16'hCAFE, 1'b1, 32'hFFFF_FFFF, 8'hFF));
        send_item(offer_item(16'h1111, 1'b0, 32'hFFFF_FFFF, 8'd0));
        send_item(offer_item(16'h2222, 1'b0, 32'h0000_0000, 8'd0));
        send_item(read_item(8'd0, 4'd1));
        drain_results();
    endtask

    task automatic test_random_stream(input logic [rs_pkg::CFG_DATA_W-1:0] k_val,
                                      input logic [rs_pkg::CFG_DATA_W-1:0] w_val,
                                      input int unsigned send_pct, input int unsigned rx_pct,
                                      input int unsigned n_items);
        write_reg(rs_pkg::REG_RESERVOIR_SIZE, k_val);
        write_reg(rs_pkg::REG_ELEMENT_COUNT, w_val);
        send_idle_pct = send_pct;
        stall_pct = rx_pct;
        run_traffic(n_items);
        drain_results();
    endtask

    task automatic test_output_hold();
        write_reg(rs_pkg::REG_RESERVOIR_SIZE, 9'd2);
        write_reg(rs_pkg::REG_ELEMENT_COUNT, 9'd2);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_len = HOLD_CYCLES;
        run_traffic(40);
        drain_results();
        send_idle_pct = 27;
        stall_pct = 27;
        run_traffic(30);
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_len != 0)
        begin
            hold_left = hold_len;
            hold_len = 0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        rs_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $error("result arrived with no item outstanding");
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0h, actual %0h", want.read_value,
                           out_item.read_value);
                    failures++;
                end
                if (out_item.kept !== want.kept)
                begin
                    $error("kept: expected %0b, actual %0b", want.kept, out_item.kept);
                    failures++;
                end
                if (out_item.slot !== want.slot)
                begin
                    $error("slot: expected %0d, actual %0d", want.slot, out_item.slot);
                    failures++;
                end
                if (out_item.seen_count !== want.seen_count)
                begin
                    $error("seen_count: expected %0d, actual %0d", want.seen_count,
                           out_item.seen_count);
                    failures++;
                end
                if (out_item.error !== want.error)
                begin
                    $error("error: expected %0b, actual %0b", want.error, out_item.error);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_limits();
        test_record_framing();
        test_random_stream(9'd511, 9'd1, 0, 0, 220);
        test_random_stream(9'd6, 9'd16, 62, 0, 160);
        test_random_stream(9'd3, 9'd3, 0, 62, 150);
        test_random_stream(9'd256, 9'd5, 27, 27, 130);
        test_output_hold();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            failures++;
        end
        $display("Sent %0d items: %0d reads and %0d records, %0d of them kept, %0d flagged.",
                 items_sent, reads_sent, records_started, records_kept, errors_flagged);
        $display("Checked %0d results over %0d register writes, idle and hold-off phases.",
                 results_checked, reg_writes);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
